// ----- hdl/osc_packet_validator_defines.svh -----
// assertion macros for the osc packet validator
// each macro samples on the rising edge of clk and is disabled in reset
`ifndef OSC_PACKET_VALIDATOR_DEFINES_SVH
`define OSC_PACKET_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OPV_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("osc packet validator check failed");
// next-cycle implication
`define OPV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("osc packet validator check failed");
`else
`define OPV_ASSERT(label, ante, cons)
`define OPV_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hdl/opv_pkg.sv -----
package opv_pkg;

  // sizing
  localparam int MAX_DEPTH = 8;
  localparam int LEN_BITS  = 16;
  localparam int PAD       = 4;
  localparam int SP_BITS   = $clog2(MAX_DEPTH + 1);
  localparam int IDX_BITS  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DEPTH_W   = 4;
  localparam int STATUS_W  = 4;

  // bundle header "#bundle" plus nul
  localparam int HDR_LEN      = 8;
  localparam int HM_BITS      = $clog2(HDR_LEN + 1);
  localparam int HDR_IDX_BITS = $clog2(HDR_LEN);
  localparam logic [7:0] BUNDLE_HDR [HDR_LEN] =
    '{8'h23, 8'h62, 8'h75, 8'h6E, 8'h64, 8'h6C, 8'h65, 8'h00};
  localparam int TIMETAG_END = 16;  // header plus 8-byte time tag
  localparam int SIZE_BYTES  = 4;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  // result kinds
  localparam logic KIND_MSG    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDARY    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NONPRINT    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_UNTERM      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_PAD     = 4'd4;
  localparam logic [STATUS_W-1:0] ST_DEGENERATE  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_SIZE_ALIGN  = 4'd6;
  localparam logic [STATUS_W-1:0] ST_PAST_PARENT = 4'd7;
  localparam logic [STATUS_W-1:0] ST_EXTRA       = 4'd8;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [LEN_BITS-1:0] address_start;
    logic [LEN_BITS-1:0] typetag_start;
    logic [LEN_BITS-1:0] contents_start;
    logic [LEN_BITS-1:0] contents_end;
    logic [DEPTH_W-1:0]  depth;
    logic                is_last;
  } out_item_t;

  // up to two results written into the queue in the same cycle
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

// ----- hdl/osc_packet_validator.sv -----
// osc packet validator
// in channel: one packet byte per item (data_byte, last), last flags the final
//   byte of a packet; valid/ready handshake
// out channel: one result per message found (kind 0, offsets and nesting depth)
//   and one end-of-packet status result (kind 1) on the last byte; a byte
//   that completes a message and is also last gives two results, is_last
//   marking the second
// a result is offered on out once its byte has left the input register and
//   been written into the result queue; a full queue holds the byte back
// throughput: one byte per cycle while the queue has room; each byte is parsed
//   in a single pass of compare logic between input register and result queue
// the result queue holds four results; a byte moves on only while two slots
//   are free, so when the receiver stalls in_ready drops once three results
//   are waiting and nothing is lost
// after an error the first status is kept and bytes are dropped until last
// reset (rst, synchronous, active high) empties both stages and returns the
//   parser to the start of a packet; no clearing pass is needed
`include "osc_packet_validator_defines.svh"

module osc_packet_validator
  import opv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // parser phases, one-hot
  typedef enum logic [6:0] {
    PH_ADDR_STR = 7'b0000001,
    PH_ADDR_PAD = 7'b0000010,
    PH_TAG_STR  = 7'b0000100,
    PH_TAG_PAD  = 7'b0001000,
    PH_CONTENTS = 7'b0010000,
    PH_TIMETAG  = 7'b0100000,
    PH_SIZE     = 7'b1000000
  } phase_t;

  // outcome of one string byte
  typedef enum logic [1:0] {
    SB_STAY = 2'd0,
    SB_PAD  = 2'd1,
    SB_DONE = 2'd2,
    SB_FAIL = 2'd3
  } sb_t;

  localparam logic [LEN_BITS-1:0] LEN_MAX  = '1;
  localparam logic [LEN_BITS-1:0] PAD_MASK = LEN_BITS'(PAD - 1);

  // string byte: printable text, then nul padding to the pad boundary
  function automatic sb_t string_step(input logic [7:0] b,
                                      input logic [LEN_BITS-1:0] start,
                                      input logic [LEN_BITS-1:0] np,
                                      input logic in_pad);
    logic aligned;
    sb_t  res;
    aligned = (((np - start) & PAD_MASK) == '0);
    if (!in_pad) begin
      if (b == 8'h00) begin
        res = aligned ? SB_DONE : SB_PAD;
      end else if (b < 8'h20 || b > 8'h7E) begin
        res = SB_FAIL;
      end else begin
        res = SB_STAY;
      end
    end else if (b != 8'h00) begin
      res = SB_FAIL;
    end else begin
      res = aligned ? SB_DONE : SB_PAD;
    end
    return res;
  endfunction

  // checks made when an element (or the packet) ends
  function automatic logic [STATUS_W-1:0] close_code(input logic is_msg,
                                                     input phase_t ph,
                                                     input logic [LEN_BITS-1:0] pos,
                                                     input logic [LEN_BITS-1:0] aoff,
                                                     input logic [1:0] wb);
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    if (is_msg) begin
      if (((pos - aoff) & PAD_MASK) != '0) begin
        st = ST_BOUNDARY;
      end else if (ph == PH_ADDR_STR || ph == PH_TAG_STR) begin
        st = ST_UNTERM;
      end else if (ph == PH_ADDR_PAD || ph == PH_TAG_PAD) begin
        st = ST_BAD_PAD;
      end
    end else begin
      if (ph == PH_TIMETAG) begin
        st = ST_DEGENERATE;
      end else if (ph == PH_SIZE && wb != 2'd0) begin
        st = ST_EXTRA;
      end
    end
    return st;
  endfunction

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;
  logic       room;
  logic       advance;

  // parser state
  logic [LEN_BITS-1:0] position, position_next;
  phase_t              phase, phase_next;
  logic [HM_BITS-1:0]  header_match, header_match_next;
  logic [LEN_BITS-1:0] end_stack [MAX_DEPTH];
  logic [SP_BITS-1:0]  sp, sp_next;
  logic [31:0]         size_accum, size_accum_next;
  logic [1:0]          word_bytes, word_bytes_next;
  logic [LEN_BITS-1:0] address_offset, address_offset_next;
  logic [LEN_BITS-1:0] typetag_offset, typetag_offset_next;
  logic [STATUS_W-1:0] error_code, error_code_next;
  logic                top_is_message, top_is_message_next;

  // per-byte work
  logic [LEN_BITS-1:0] np;
  logic [LEN_BITS-1:0] k;
  logic [SP_BITS-1:0]  sp_dec;
  logic [LEN_BITS-1:0] top;
  logic [SP_BITS-1:0]  keep_cnt;
  logic                hdr_hit;
  sb_t                 sb;
  logic [31:0]         size_word;
  logic [32:0]         elem_end;
  logic                stack_push;
  logic [STATUS_W-1:0] close_st;
  logic [STATUS_W-1:0] final_st;
  logic                emit_msg;
  push_t               push;
  out_item_t           msg_item;
  out_item_t           status_item;

  // byte moves to the parser only with room for two results
  assign advance  = stage_valid && room;
  assign in_ready = !stage_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= in_data.data_byte;
      stage_last <= in_data.last;
    end
  end

  // innermost open element and how many open elements survive a close
  assign sp_dec = sp - 1'b1;
  assign top    = end_stack[sp_dec[IDX_BITS-1:0]];
  assign np     = position + 1'b1;
  assign k      = position - address_offset;

  always_comb begin
    keep_cnt = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      // nested ends never exceed their parents, so equal ends sit on top
      if (SP_BITS'(i) < sp && end_stack[i] != np) begin
        keep_cnt = keep_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    position_next       = position;
    phase_next          = phase;
    header_match_next   = header_match;
    sp_next             = sp;
    size_accum_next     = size_accum;
    word_bytes_next     = word_bytes;
    address_offset_next = address_offset;
    typetag_offset_next = typetag_offset;
    error_code_next     = error_code;
    top_is_message_next = top_is_message;
    hdr_hit             = 1'b0;
    sb                  = SB_STAY;
    size_word           = {size_accum[23:0], stage_byte};
    elem_end            = 33'(np) + 33'(size_word);
    stack_push          = 1'b0;
    close_st            = ST_OK;
    final_st            = ST_OK;
    emit_msg            = 1'b0;

    if (error_code == ST_OK) begin
      if (position == LEN_MAX) begin
        error_code_next = ST_TOO_LONG;
      end else begin
        case (phase)
          PH_ADDR_STR, PH_ADDR_PAD: begin
            hdr_hit = (k < LEN_BITS'(HDR_LEN)) && (header_match == k[HM_BITS-1:0]) &&
                      (stage_byte == BUNDLE_HDR[k[HDR_IDX_BITS-1:0]]);
            if (hdr_hit && header_match == HM_BITS'(HDR_LEN - 1)) begin
              // full bundle header: on to the time tag
              header_match_next   = HM_BITS'(HDR_LEN);
              phase_next          = PH_TIMETAG;
              top_is_message_next = 1'b0;
            end else begin
              if (hdr_hit) begin
                header_match_next = header_match + 1'b1;
              end
              sb = string_step(stage_byte, address_offset, np, phase == PH_ADDR_PAD);
              case (sb)
                SB_PAD:  phase_next = PH_ADDR_PAD;
                SB_DONE: begin
                  typetag_offset_next = np;
                  phase_next          = PH_TAG_STR;
                end
                SB_FAIL: error_code_next = (phase == PH_ADDR_PAD) ? ST_BAD_PAD : ST_NONPRINT;
                default: ;
              endcase
            end
          end
          PH_TAG_STR, PH_TAG_PAD: begin
            sb = string_step(stage_byte, typetag_offset, np, phase == PH_TAG_PAD);
            case (sb)
              SB_PAD:  phase_next = PH_TAG_PAD;
              SB_DONE: begin
                phase_next = PH_CONTENTS;
                emit_msg   = 1'b1;
              end
              SB_FAIL: error_code_next = (phase == PH_TAG_PAD) ? ST_BAD_PAD : ST_NONPRINT;
              default: ;
            endcase
          end
          PH_TIMETAG: begin
            if ((np - address_offset) >= LEN_BITS'(TIMETAG_END)) begin
              phase_next      = PH_SIZE;
              word_bytes_next = 2'd0;
              size_accum_next = '0;
            end
          end
          PH_SIZE: begin
            size_accum_next = size_word;
            if (word_bytes != 2'(SIZE_BYTES - 1)) begin
              word_bytes_next = word_bytes + 1'b1;
            end else begin
              // size word complete: check it and open the child element
              word_bytes_next = 2'd0;
              if (size_word[1:0] != 2'd0) begin
                error_code_next = ST_SIZE_ALIGN;
              end else if (size_word == '0 || size_word[31]) begin
                error_code_next = ST_BOUNDARY;
              end else if (sp != '0 && elem_end > 33'(top)) begin
                error_code_next = ST_PAST_PARENT;
              end else if (elem_end > 33'(LEN_MAX) || sp >= SP_BITS'(MAX_DEPTH)) begin
                error_code_next = ST_TOO_LONG;
              end else begin
                stack_push          = 1'b1;
                sp_next             = sp + 1'b1;
                address_offset_next = np;
                header_match_next   = '0;
                phase_next          = PH_ADDR_STR;
                top_is_message_next = 1'b1;
              end
            end
          end
          default: ;
        endcase

        position_next = np;

        // element end reached: check the innermost, then pop every element
        // that ends here (a fresh child always ends later)
        if (error_code_next == ST_OK && !stack_push && sp != '0 && top == np) begin
          close_st = close_code(top_is_message_next, phase_next, np,
                                address_offset_next, word_bytes_next);
          if (close_st != ST_OK) begin
            error_code_next = close_st;
          end else begin
            sp_next             = keep_cnt;
            phase_next          = PH_SIZE;
            word_bytes_next     = 2'd0;
            size_accum_next     = '0;
            top_is_message_next = 1'b0;
          end
        end
      end
    end

    if (stage_last) begin
      final_st = error_code_next;
      if (final_st == ST_OK) begin
        if (sp_next != '0) begin
          final_st = ST_PAST_PARENT;
        end else begin
          final_st = close_code(top_is_message_next, phase_next, position_next,
                                address_offset_next, word_bytes_next);
        end
      end
      // back to the start of a packet
      position_next       = '0;
      phase_next          = PH_ADDR_STR;
      header_match_next   = '0;
      sp_next             = '0;
      size_accum_next     = '0;
      word_bytes_next     = 2'd0;
      address_offset_next = '0;
      typetag_offset_next = '0;
      error_code_next     = ST_OK;
      top_is_message_next = 1'b1;
    end
  end

  // result items
  always_comb begin
    msg_item                = '0;
    msg_item.kind           = KIND_MSG;
    msg_item.status         = ST_OK;
    msg_item.address_start  = address_offset;
    msg_item.typetag_start  = typetag_offset;
    msg_item.contents_start = np;
    msg_item.contents_end   = (sp != '0) ? top : '0;
    msg_item.depth          = DEPTH_W'(sp);
    msg_item.is_last        = !stage_last;

    status_item         = '0;
    status_item.kind    = KIND_STATUS;
    status_item.status  = final_st;
    status_item.is_last = 1'b1;

    push.cnt    = advance ? (2'(emit_msg) + 2'(stage_last)) : 2'd0;
    push.first  = emit_msg ? msg_item : status_item;
    push.second = status_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      phase          <= PH_ADDR_STR;
      header_match   <= '0;
      sp             <= '0;
      size_accum     <= '0;
      word_bytes     <= 2'd0;
      address_offset <= '0;
      typetag_offset <= '0;
      error_code     <= ST_OK;
      top_is_message <= 1'b1;
    end else if (advance) begin
      position       <= position_next;
      phase          <= phase_next;
      header_match   <= header_match_next;
      sp             <= sp_next;
      size_accum     <= size_accum_next;
      word_bytes     <= word_bytes_next;
      address_offset <= address_offset_next;
      typetag_offset <= typetag_offset_next;
      error_code     <= error_code_next;
      top_is_message <= top_is_message_next;
    end
  end

  // end offset stack, entries valid below sp only
  always_ff @(posedge clk) begin
    if (advance && stack_push) begin
      end_stack[sp[IDX_BITS-1:0]] <= elem_end[LEN_BITS-1:0];
    end
  end

  opv_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a packet's last byte leaves the parser at the start of a fresh packet
  `OPV_ASSERT_NXT(a_packet_restart, advance && stage_last, position == '0 && sp == '0 && error_code == ST_OK)
  // no message is reported once an error is latched
  `OPV_ASSERT(a_msg_clean, advance && emit_msg, error_code == ST_OK)
  // a latched error holds until the packet ends
  `OPV_ASSERT_NXT(a_error_holds, error_code != ST_OK && !(advance && stage_last), error_code == $past(error_code))

endmodule

// ----- hdl/opv_result_fifo.sv -----
module opv_result_fifo
  import opv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t           mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] head;
  logic [PTR_BITS-1:0] tail;
  logic [CNT_BITS-1:0] count;
  logic                pop;
  logic [PTR_BITS-1:0] tail_plus;

  assign pop       = out_valid && out_ready;
  assign tail_plus = tail + 1'b1;
  assign out_valid = (count != '0);
  assign out_data  = mem[head];
  // space for two results, counted without this cycle's pop
  assign room      = (count <= CNT_BITS'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if (push.cnt != 2'd0 && PTR_BITS'(i) == tail) begin
        mem[i] <= push.first;
      end else if (push.cnt == 2'd2 && PTR_BITS'(i) == tail_plus) begin
        mem[i] <= push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_BITS'(push.cnt);
      head  <= head + PTR_BITS'(pop);
      count <= count + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
    end
  end

endmodule
